// File: rtl/gibs_pkg.sv
// Shared types, constants and helpers of the greedy IoU box suppression block.
package gibs_pkg;

   localparam int MAX_KEPT = 64;
   localparam int KEPT_AW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W    = $clog2(MAX_KEPT + 1);

   localparam int CSR_AW = 3;
   localparam logic ADDR_IOU_THRESHOLD = 1'b0;
   localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;

   // Edge positions in 2^-15 units and overlaps are held in 20 signed bits.
   localparam int SPAN_W  = 20;
   localparam int INTER_W = 36;
   localparam int PROD_W  = 52;

   // Packed so that center_x sits in bits 15..0 and box_height in 63..48.
   typedef struct packed {
      logic [15:0] h;
      logic [15:0] w;
      logic [15:0] cy;
      logic [15:0] cx;
   } box_type;

   typedef struct packed {
      logic valid;
      logic over;
      logic busy;
   } iou_res_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // Signed overlap of two spans given by center and size.
   function automatic logic signed [SPAN_W-1:0] span_overlap(
      input logic [15:0] ca, input logic [15:0] sa,
      input logic [15:0] cb, input logic [15:0] sb);
      logic signed [SPAN_W-1:0] la, ra, lb, rb, lo, hi;
      la = $signed({3'b000, ca, 1'b0}) - $signed({4'b0000, sa});
      ra = $signed({3'b000, ca, 1'b0}) + $signed({4'b0000, sa});
      lb = $signed({3'b000, cb, 1'b0}) - $signed({4'b0000, sb});
      rb = $signed({3'b000, cb, 1'b0}) + $signed({4'b0000, sb});
      lo = (la > lb) ? la : lb;
      hi = (ra < rb) ? ra : rb;
      return hi - lo;
   endfunction

endpackage

// File: rtl/gibs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gibs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/gibs_iou.sv
// Pipelined IoU limit test of the current box against one stored box per cycle.
module gibs_iou (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  gibs_pkg::box_type  stored_box,
   input  gibs_pkg::box_type  cur_box,
   input  logic [31:0]        cur_area,
   input  logic [15:0]        iou_threshold,
   output gibs_pkg::iou_res_type res
);
   import gibs_pkg::*;

   logic                     v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [SPAN_W-1:0] ow_ff, oh_ff;
   logic [15:0]              bw_ff, bh_ff;
   logic [INTER_W-1:0]       inter2_ff, inter3_ff, inter4_ff;
   logic [31:0]              area_b_ff;
   logic [INTER_W-1:0]       union_ff;
   logic [PROD_W-1:0]        prod_ff;
   logic                     over_ff;

   logic signed [SPAN_W-1:0] ow_in, oh_in;
   logic [INTER_W-1:0]       inter_in, union_in;
   logic [PROD_W-1:0]        prod_in;
   logic                     over_in;

   always_comb begin
      ow_in = span_overlap(stored_box.cx, stored_box.w, cur_box.cx, cur_box.w);
      oh_in = span_overlap(stored_box.cy, stored_box.h, cur_box.cy, cur_box.h);
      // A negative extent on either axis means the boxes do not touch.
      if (!ow_ff[SPAN_W-1] && !oh_ff[SPAN_W-1]) begin
         inter_in = INTER_W'(ow_ff[17:0]) * INTER_W'(oh_ff[17:0]);
      end else begin
         inter_in = '0;
      end
      union_in = {2'b00, cur_area, 2'b00} + {2'b00, area_b_ff, 2'b00} - inter2_ff;
      prod_in  = PROD_W'(iou_threshold) * PROD_W'(union_ff);
      over_in  = {inter4_ff, 16'h0000} > prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      ow_ff     <= ow_in;
      oh_ff     <= oh_in;
      bw_ff     <= stored_box.w;
      bh_ff     <= stored_box.h;
      inter2_ff <= inter_in;
      area_b_ff <= bw_ff * bh_ff;
      inter3_ff <= inter2_ff;
      union_ff  <= union_in;
      inter4_ff <= inter3_ff;
      prod_ff   <= prod_in;
      over_ff   <= over_in;
   end

   assign res.valid = v5_ff;
   assign res.over  = over_ff;
   assign res.busy  = v1_ff | v2_ff | v3_ff | v4_ff | v5_ff;
endmodule

// File: rtl/greedy_iou_box_suppression.sv
// Top level of the greedy IoU box suppression block.
//
// Boxes arrive on the req_ channel (valid/ready) and each one yields exactly one
// result on the rsp_ channel: keep, and store_overflow when a kept box found the
// store full. The IoU limit is written through the APB port at byte address 0.
// An active box is tested against every kept box of the current pass, one stored
// box per cycle through a five-stage compare pipeline fed from the box RAM.
// After its scan, an active box waits for the compare pipeline to drain before
// its result; an active box that meets an empty store skips the scan, and an
// inactive box goes straight to its result. One box is in work at a time;
// req_ready is high only while the block is idle, so the next request can be
// taken in the cycle after the result is registered. The result sits in an
// output register, so the next request is accepted while it waits; if the
// receiver still stalls when the next result is done, the block holds until
// it is taken.
// Reset empties the store (count to zero, no clearing pass), restores the
// limit to 29491 and drops any pending result.
module greedy_iou_box_suppression (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_start_set,
   input  logic [15:0]                 req_center_x,
   input  logic [15:0]                 req_center_y,
   input  logic [15:0]                 req_box_width,
   input  logic [15:0]                 req_box_height,
   input  logic                        req_active,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_keep,
   output logic                        rsp_store_overflow,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gibs_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import gibs_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [KEPT_AW-1:0] idx_ff, idx_in;
   logic              hit_ff, hit_in;
   logic              active_ff;
   box_type           cur_ff;
   logic [31:0]       area_ff;
   logic [15:0]       thr_ff;
   logic              v0_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_keep_ff, rsp_ovf_ff;

   logic              req_fire, issue, out_free, keep, room, wr_en;
   box_type           req_box, stored_box;
   iou_res_type       res;

   assign req_box = '{h: req_box_height, w: req_box_width,
                      cy: req_center_y, cx: req_center_x};

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign issue     = (state_ff == ST_SCAN);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign keep      = active_ff & ~hit_ff;
   assign room      = count_ff < CNT_W'(MAX_KEPT);
   assign wr_en     = (state_ff == ST_FINISH) && out_free && keep && room;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff | (res.valid & res.over);
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               hit_in = 1'b0;
               idx_in = '0;
               if (req_start_set) begin
                  count_in = '0;
               end
               if (!req_active) begin
                  state_in = ST_FINISH;
               end else if (req_start_set || count_ff == '0) begin
                  state_in = ST_DRAIN;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (CNT_W'(idx_ff) + 1'b1 == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v0_ff && !res.busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (wr_en) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         v0_ff        <= 1'b0;
         thr_ff       <= IOU_THRESHOLD_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         v0_ff        <= issue;
         if (psel && penable && pwrite && paddr[CSR_AW-1] == ADDR_IOU_THRESHOLD) begin
            thr_ff <= pwdata[15:0];
         end
      end
      idx_ff <= idx_in;
      hit_ff <= hit_in;
      if (req_fire) begin
         cur_ff    <= req_box;
         active_ff <= req_active;
         area_ff   <= req_box_width * req_box_height;
      end
      if ((state_ff == ST_FINISH) && out_free) begin
         rsp_keep_ff <= keep;
         rsp_ovf_ff  <= keep & ~room;
      end
   end

   gibs_ram #(
      .WIDTH ($bits(box_type)),
      .DEPTH (MAX_KEPT)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[KEPT_AW-1:0]),
      .wr_data (cur_ff),
      .rd_en   (issue),
      .rd_addr (idx_ff),
      .rd_data (stored_box)
   );

   gibs_iou u_iou (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (v0_ff),
      .stored_box    (stored_box),
      .cur_box       (cur_ff),
      .cur_area      (area_ff),
      .iou_threshold (thr_ff),
      .res           (res)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_keep           = rsp_keep_ff;
   assign rsp_store_overflow = rsp_ovf_ff;

   assign prdata = (paddr[CSR_AW-1] == ADDR_IOU_THRESHOLD) ? {16'h0000, thr_ff} : 32'h0;
   assign pready = 1'b1;
endmodule

// File: bench/tb.sv
// Self-checking bench for greedy_iou_box_suppression: directed table, then random passes.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gibs_pkg::*;

   localparam logic [CSR_AW-1:0] LIMIT_ADDR = CSR_AW'(4 * ADDR_IOU_THRESHOLD);
   localparam int PHASE_ITEMS = 150;

   typedef struct packed {
      logic        start_set;
      logic [15:0] cx;
      logic [15:0] cy;
      logic [15:0] w;
      logic [15:0] h;
      logic        active;
      logic        typed;
      logic        want_keep;
      logic        want_overflow;
   } box_request;

   typedef struct packed {
      logic keep;
      logic store_overflow;
   } box_verdict;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_start_set = 1'b0;
   logic [15:0] req_center_x = '0;
   logic [15:0] req_center_y = '0;
   logic [15:0] req_box_width = '0;
   logic [15:0] req_box_height = '0;
   logic        req_active = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_keep;
   logic        rsp_store_overflow;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   greedy_iou_box_suppression uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_start_set(req_start_set), .req_center_x(req_center_x),
      .req_center_y(req_center_y), .req_box_width(req_box_width),
      .req_box_height(req_box_height), .req_active(req_active),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_keep(rsp_keep), .rsp_store_overflow(rsp_store_overflow),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Rows marked typed carry their expected verdict; the rest go through the predictor.
   box_request directed_rows [21] = '{
      '{1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b1, 16'h4000, 16'h4000, 16'h2000, 16'h2000, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b0, 16'h4000, 16'h4000, 16'h2000, 16'h2000, 1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 16'h4000, 16'h4000, 16'h2000, 16'h2000, 1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 16'h4400, 16'h4000, 16'h2000, 16'h2000, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, 16'h4800, 16'h4000, 16'h2000, 16'h2000, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, 16'hC000, 16'hC000, 16'h1000, 16'h1000, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, 16'h6000, 16'h4000, 16'h2000, 16'h2000, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b1, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b0, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b0, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
      '{1'b0, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b1, 1'b0, 1'b0},
      '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0},
      '{1'b0, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1, 1'b0, 1'b0, 1'b0},
      '{1'b1, 16'h2000, 16'h2000, 16'h0800, 16'h0800, 1'b1, 1'b1, 1'b1, 1'b0}
   };

   box_request box_requests [$];
   box_request offered;
   box_verdict expected_verdicts [$];
   box_verdict verdict_now;
   box_type    kept_store [MAX_KEPT];
   int         kept_total = 0;
   logic [15:0] iou_limit = IOU_THRESHOLD_RESET;
   int         requests_queued = 0;
   int         verdicts_checked = 0;
   int         fail_count = 0;
   int         idle_pct = 12;
   logic       stall_hold = 1'b0;

   task automatic report_mismatch(input string what);
      if (fail_count < 40) $display("[%0t] mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   // Overlap of two spans in 2^-15 units; negative when they are disjoint.
   function automatic longint edge_overlap(input logic [15:0] ca, input logic [15:0] sa,
                                           input logic [15:0] cb, input logic [15:0] sb);
      longint lo_a, hi_a, lo_b, hi_b;
      lo_a = 2 * longint'(ca) - longint'(sa);
      hi_a = 2 * longint'(ca) + longint'(sa);
      lo_b = 2 * longint'(cb) - longint'(sb);
      hi_b = 2 * longint'(cb) + longint'(sb);
      return ((hi_a < hi_b) ? hi_a : hi_b) - ((lo_a > lo_b) ? lo_a : lo_b);
   endfunction

   function automatic bit exceeds_iou(input box_type a, input box_type b);
      longint ow, oh;
      longint unsigned inter, joint;
      ow = edge_overlap(a.cx, a.w, b.cx, b.w);
      oh = edge_overlap(a.cy, a.h, b.cy, b.h);
      inter = 0;
      if (ow >= 0 && oh >= 0) inter = ow * oh;
      joint = 4 * 64'(a.w) * 64'(a.h) + 4 * 64'(b.w) * 64'(b.h) - inter;
      return (inter << 16) > (64'(iou_limit) * joint);
   endfunction

   // Updates the kept-box store as the block would and returns the verdict.
   function automatic box_verdict judge_box(input box_request r);
      box_type    cand;
      box_verdict v;
      bit         hit;
      v = '0;
      hit = 1'b0;
      if (r.start_set) kept_total = 0;
      if (!r.active) return v;
      cand = '{h: r.h, w: r.w, cy: r.cy, cx: r.cx};
      for (int i = 0; i < kept_total && !hit; i++) hit = exceeds_iou(kept_store[i], cand);
      if (hit) return v;
      v.keep = 1'b1;
      if (kept_total < MAX_KEPT) begin
         kept_store[kept_total] = cand;
         kept_total++;
      end else begin
         v.store_overflow = 1'b1;
      end
      return v;
   endfunction

   function automatic logic [15:0] nudge(input logic [15:0] v);
      int t;
      t = int'(v) + int'($urandom_range(1024)) - 512;
      if (t < 0) t = 0;
      if (t > 65535) t = 65535;
      return t[15:0];
   endfunction

   initial begin
      forever #2 clock = ~clock;
   end

   // Request side: holds the payload until accepted, predicts at acceptance.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            verdict_now = judge_box(offered);
            if (offered.typed) verdict_now = '{offered.want_keep, offered.want_overflow};
            expected_verdicts = {expected_verdicts, verdict_now};
         end
         if (!req_valid || req_ready) begin
            if (box_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
               offered = box_requests.pop_front();
               req_start_set  <= offered.start_set;
               req_center_x   <= offered.cx;
               req_center_y   <= offered.cy;
               req_box_width  <= offered.w;
               req_box_height <= offered.h;
               req_active     <= offered.active;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("result with no request waiting");
            end else begin
               verdict_now = expected_verdicts.pop_front();
               if (rsp_keep !== verdict_now.keep)
                  report_mismatch($sformatf("keep %b, expected %b",
                                            rsp_keep, verdict_now.keep));
               if (rsp_store_overflow !== verdict_now.store_overflow)
                  report_mismatch($sformatf("store_overflow %b, expected %b",
                                            rsp_store_overflow, verdict_now.store_overflow));
               verdicts_checked++;
            end
         end
         rsp_ready <= !stall_hold && ($urandom_range(99) >= idle_pct);
      end
   end

   // Long receiver stall while requests keep coming, so the block backs up.
   initial begin
      while (verdicts_checked < 250) @(posedge clock);
      stall_hold <= 1'b1;
      repeat (400) @(posedge clock);
      stall_hold <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("greedy_iou_box_suppression verification failed");
      $finish;
   end

   task automatic wait_drained(input int settle);
      while (verdicts_checked < requests_queued) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Writes the IoU limit over APB, then reads it back.
   task automatic set_iou_limit(input logic [15:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= LIMIT_ADDR;
      pwdata  <= {16'h0000, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      iou_limit = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[15:0] !== value)
         report_mismatch($sformatf("iou_threshold reads %h, wrote %h", prdata[15:0], value));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Random class passes: the first pass of each phase is long enough to fill the store.
   task automatic queue_phase(input int count);
      box_request r;
      box_type    recent [$];
      box_type    base;
      int         pass_left;
      int         pick;
      bit         first_pass;
      pass_left = 0;
      first_pass = 1'b1;
      for (int n = 0; n < count; n++) begin
         r = '0;
         if (pass_left == 0) begin
            r.start_set = 1'b1;
            recent.delete();
            if (first_pass || $urandom_range(99) < 20) pass_left = $urandom_range(130, 100);
            else pass_left = $urandom_range(12, 1);
            first_pass = 1'b0;
         end else begin
            r.start_set = ($urandom_range(99) < 3);
         end
         pass_left--;
         r.active = ($urandom_range(99) < 85);
         pick = $urandom_range(99);
         if (pick < 30 && recent.size() > 0) begin
            // A near copy of an earlier box lands close to the IoU limit.
            base = recent[$urandom_range(recent.size() - 1)];
            r.cx = nudge(base.cx);
            r.cy = nudge(base.cy);
            r.w  = nudge(base.w);
            r.h  = nudge(base.h);
         end else if (pick < 50) begin
            r.cx = 16'($urandom);
            r.cy = 16'($urandom);
            r.w  = 16'($urandom);
            r.h  = 16'($urandom);
         end else if (pick < 55) begin
            r.cx = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            r.cy = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            r.w  = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            r.h  = $urandom_range(1) ? 16'hFFFF : 16'h0000;
         end else begin
            r.cx = 16'($urandom);
            r.cy = 16'($urandom);
            r.w  = 16'($urandom_range(16'h0C00));
            r.h  = 16'($urandom_range(16'h0C00));
         end
         recent = {recent, box_type'{h: r.h, w: r.w, cy: r.cy, cx: r.cx}};
         box_requests = {box_requests, r};
         requests_queued++;
      end
   endtask

   initial begin
      logic [15:0] limits [4];
      limits = '{16'h0000, 16'hFFFF, 16'($urandom_range(65534, 1)), 16'h8000};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // The directed rows run with the limit left at its reset value.
      foreach (directed_rows[i]) begin
         box_requests = {box_requests, directed_rows[i]};
         requests_queued++;
      end
      for (int p = 0; p < 4; p++) begin
         wait_drained(8);
         set_iou_limit(limits[p]);
         idle_pct = (p == 2) ? 0 : 12;
         queue_phase(PHASE_ITEMS);
      end
      wait_drained(100);
      if (fail_count == 0) begin
         $display("greedy_iou_box_suppression verification clean");
      end else begin
         $display("greedy_iou_box_suppression verification failed");
      end
      $finish;
   end

endmodule
